/* design/spq_pkg.sv */
package spq_pkg;

  localparam int DEF_DEPTH          = 16;
  localparam int DEF_VALUE_WIDTH    = 32;
  localparam int DEF_PRIORITY_WIDTH = 8;
  localparam int MAX_RESULTS        = 16;

  localparam logic [2:0] FUNC_INSERT    = 3'd0;
  localparam logic [2:0] FUNC_POP       = 3'd1;
  localparam logic [2:0] FUNC_CLEAR     = 3'd2;
  localparam logic [2:0] FUNC_DEL_PRI   = 3'd3;
  localparam logic [2:0] FUNC_DEL_MATCH = 3'd4;
  localparam logic [2:0] FUNC_READ_ALL  = 3'd5;
  localparam logic [2:0] FUNC_READ_PRI  = 3'd6;
  localparam logic [2:0] FUNC_UNUSED    = 3'd7;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;
  localparam logic [1:0] STATUS_NO_MATCH = 2'd3;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] item_value;
    logic [7:0]         item_priority;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic [7:0]         out_priority;
    logic [4:0]         removed_count;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } spq_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_free;
  } spq_sts_t;

endpackage

/* design/spq_ctrl.sv */
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::spq_sts_t sts,
  output spq_pkg::spq_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.walk_done) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FINISH: begin
        // hold until the output register can take the closing item
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/spq_datapath.sv */
module spq_datapath #(
  parameter int DEPTH          = spq_pkg::DEF_DEPTH,
  parameter int VALUE_WIDTH    = spq_pkg::DEF_VALUE_WIDTH,
  parameter int PRIORITY_WIDTH = spq_pkg::DEF_PRIORITY_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::in_item_t  in_data,
  input  spq_pkg::spq_cmd_t  cmd,
  output spq_pkg::spq_sts_t  sts,
  input  logic               out_stall,
  output logic               out_valid,
  output spq_pkg::out_item_t out_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int RES_W = $clog2(spq_pkg::MAX_RESULTS + 1);

  logic [VALUE_WIDTH-1:0]    mem_value [DEPTH];
  logic [PRIORITY_WIDTH-1:0] mem_pri   [DEPTH];

  logic [CNT_W-1:0]          occ_r, occ_nxt;
  logic [2:0]                op_r, op_nxt;
  logic [VALUE_WIDTH-1:0]    val_r, val_nxt;
  logic [PRIORITY_WIDTH-1:0] pri_r, pri_nxt;
  logic                      quick_r, quick_nxt;
  logic [1:0]                quick_status_r, quick_status_nxt;
  logic [CNT_W-1:0]          rd_idx_r, rd_idx_nxt;
  logic                      st_valid_r, st_valid_nxt;
  logic [CNT_W-1:0]          st_idx_r, st_idx_nxt;
  logic [VALUE_WIDTH-1:0]    rd_value_r;
  logic [PRIORITY_WIDTH-1:0] rd_pri_r;
  logic [CNT_W-1:0]          wr_idx_r, wr_idx_nxt;
  logic                      flag_r, flag_nxt;
  logic [VALUE_WIDTH-1:0]    carry_value_r, carry_value_nxt;
  logic [PRIORITY_WIDTH-1:0] carry_pri_r, carry_pri_nxt;
  logic                      pend_valid_r, pend_valid_nxt;
  logic [VALUE_WIDTH-1:0]    pend_value_r, pend_value_nxt;
  logic [PRIORITY_WIDTH-1:0] pend_pri_r, pend_pri_nxt;
  logic [RES_W-1:0]          cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  spq_pkg::out_item_t        out_r, out_nxt;

  logic                      is_read, limit, pri_eq, val_eq, match_rd, proc;
  logic                      out_free, blocked, adv, issue, skip;
  logic                      wr_en;
  logic [CNT_W-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0]    wr_value;
  logic [PRIORITY_WIDTH-1:0] wr_pri;

  assign is_read  = (op_r == spq_pkg::FUNC_READ_ALL) || (op_r == spq_pkg::FUNC_READ_PRI);
  assign limit    = is_read && (cnt_r == RES_W'(spq_pkg::MAX_RESULTS));
  assign pri_eq   = (rd_pri_r == pri_r);
  assign val_eq   = (rd_value_r == val_r);
  assign match_rd = (op_r == spq_pkg::FUNC_READ_ALL) || pri_eq;
  assign proc     = st_valid_r && !limit;
  assign out_free = !out_valid_r || !out_stall;
  assign blocked  = proc && is_read && match_rd && pend_valid_r && !out_free;
  assign adv      = cmd.step && !blocked;
  assign issue    = adv && (rd_idx_r < occ_r) && !limit;
  assign skip     = !flag_r && ((op_r == spq_pkg::FUNC_POP) || (val_eq && pri_eq));

  assign sts.walk_done = quick_r || limit || (!st_valid_r && (rd_idx_r == occ_r));
  assign sts.out_free  = out_free;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

  always_comb begin
    occ_nxt          = occ_r;
    op_nxt           = op_r;
    val_nxt          = val_r;
    pri_nxt          = pri_r;
    quick_nxt        = quick_r;
    quick_status_nxt = quick_status_r;
    rd_idx_nxt       = rd_idx_r;
    st_valid_nxt     = st_valid_r;
    st_idx_nxt       = st_idx_r;
    wr_idx_nxt       = wr_idx_r;
    flag_nxt         = flag_r;
    carry_value_nxt  = carry_value_r;
    carry_pri_nxt    = carry_pri_r;
    pend_valid_nxt   = pend_valid_r;
    pend_value_nxt   = pend_value_r;
    pend_pri_nxt     = pend_pri_r;
    cnt_nxt          = cnt_r;
    out_nxt          = out_r;
    out_valid_nxt    = out_valid_r && out_stall;
    wr_en            = 1'b0;
    wr_addr          = st_idx_r;
    wr_value         = rd_value_r;
    wr_pri           = rd_pri_r;

    if (cmd.load) begin
      op_nxt         = in_data.func;
      val_nxt        = VALUE_WIDTH'($unsigned(in_data.item_value));
      pri_nxt        = PRIORITY_WIDTH'($unsigned(in_data.item_priority));
      rd_idx_nxt     = '0;
      st_valid_nxt   = 1'b0;
      wr_idx_nxt     = '0;
      flag_nxt       = 1'b0;
      pend_valid_nxt = 1'b0;
      cnt_nxt        = '0;
      quick_nxt        = 1'b0;
      quick_status_nxt = spq_pkg::STATUS_OK;
      case (in_data.func)
        spq_pkg::FUNC_INSERT: begin
          if (occ_r >= CNT_W'(DEPTH)) begin
            quick_nxt        = 1'b1;
            quick_status_nxt = spq_pkg::STATUS_FULL;
          end
        end
        spq_pkg::FUNC_UNUSED: begin
          quick_nxt = 1'b1;
        end
        default: begin
          if (occ_r == '0) begin
            quick_nxt        = 1'b1;
            quick_status_nxt = spq_pkg::STATUS_EMPTY;
          end else if (in_data.func == spq_pkg::FUNC_CLEAR) begin
            quick_nxt = 1'b1;
          end
        end
      endcase
    end

    if (adv) begin
      st_valid_nxt = issue;
      if (issue) begin
        rd_idx_nxt = rd_idx_r + 1'b1;
        st_idx_nxt = rd_idx_r;
      end
      if (proc) begin
        case (op_r)
          spq_pkg::FUNC_INSERT: begin
            // place the new entry ahead of the first higher number, then ripple
            if (!flag_r && (rd_pri_r > pri_r)) begin
              wr_en           = 1'b1;
              wr_value        = val_r;
              wr_pri          = pri_r;
              carry_value_nxt = rd_value_r;
              carry_pri_nxt   = rd_pri_r;
              flag_nxt        = 1'b1;
            end else if (flag_r) begin
              wr_en           = 1'b1;
              wr_value        = carry_value_r;
              wr_pri          = carry_pri_r;
              carry_value_nxt = rd_value_r;
              carry_pri_nxt   = rd_pri_r;
            end
          end
          spq_pkg::FUNC_POP, spq_pkg::FUNC_DEL_MATCH: begin
            if (skip) begin
              flag_nxt       = 1'b1;
              pend_value_nxt = rd_value_r;
              pend_pri_nxt   = rd_pri_r;
            end else begin
              wr_en      = 1'b1;
              wr_addr    = wr_idx_r;
              wr_idx_nxt = wr_idx_r + 1'b1;
            end
          end
          spq_pkg::FUNC_DEL_PRI: begin
            if (!pri_eq) begin
              wr_en      = 1'b1;
              wr_addr    = wr_idx_r;
              wr_idx_nxt = wr_idx_r + 1'b1;
            end
          end
          spq_pkg::FUNC_READ_ALL, spq_pkg::FUNC_READ_PRI: begin
            // hold one match back so the final one can carry last
            if (match_rd) begin
              if (pend_valid_r) begin
                out_valid_nxt         = 1'b1;
                out_nxt.status        = spq_pkg::STATUS_OK;
                out_nxt.out_value     = 32'(pend_value_r);
                out_nxt.out_priority  = 8'(pend_pri_r);
                out_nxt.removed_count = '0;
                out_nxt.last          = 1'b0;
              end
              pend_valid_nxt = 1'b1;
              pend_value_nxt = rd_value_r;
              pend_pri_nxt   = rd_pri_r;
              cnt_nxt        = cnt_r + 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (cmd.finish) begin
      out_valid_nxt         = 1'b1;
      out_nxt.status        = spq_pkg::STATUS_OK;
      out_nxt.out_value     = '0;
      out_nxt.out_priority  = '0;
      out_nxt.removed_count = '0;
      out_nxt.last          = 1'b1;
      if (quick_r) begin
        out_nxt.status = quick_status_r;
        if ((op_r == spq_pkg::FUNC_CLEAR) && (quick_status_r == spq_pkg::STATUS_OK)) begin
          out_nxt.removed_count = 5'(occ_r);
          occ_nxt               = '0;
        end
      end else begin
        case (op_r)
          spq_pkg::FUNC_INSERT: begin
            wr_en    = 1'b1;
            wr_addr  = occ_r;
            wr_value = flag_r ? carry_value_r : val_r;
            wr_pri   = flag_r ? carry_pri_r : pri_r;
            occ_nxt  = occ_r + 1'b1;
          end
          spq_pkg::FUNC_POP: begin
            out_nxt.out_value     = 32'(pend_value_r);
            out_nxt.out_priority  = 8'(pend_pri_r);
            out_nxt.removed_count = 5'd1;
            occ_nxt               = occ_r - 1'b1;
          end
          spq_pkg::FUNC_DEL_PRI: begin
            out_nxt.removed_count = 5'(occ_r - wr_idx_r);
            if (wr_idx_r == occ_r) begin
              out_nxt.status = spq_pkg::STATUS_NO_MATCH;
            end
            occ_nxt = wr_idx_r;
          end
          spq_pkg::FUNC_DEL_MATCH: begin
            if (flag_r) begin
              out_nxt.removed_count = 5'd1;
              occ_nxt               = occ_r - 1'b1;
            end else begin
              out_nxt.status = spq_pkg::STATUS_NO_MATCH;
            end
          end
          spq_pkg::FUNC_READ_ALL, spq_pkg::FUNC_READ_PRI: begin
            if (pend_valid_r) begin
              out_nxt.out_value    = 32'(pend_value_r);
              out_nxt.out_priority = 8'(pend_pri_r);
            end else begin
              out_nxt.status = spq_pkg::STATUS_NO_MATCH;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_value[wr_addr[IDX_W-1:0]] <= wr_value;
      mem_pri[wr_addr[IDX_W-1:0]]   <= wr_pri;
    end
    if (issue) begin
      rd_value_r <= mem_value[rd_idx_r[IDX_W-1:0]];
      rd_pri_r   <= mem_pri[rd_idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      quick_r     <= 1'b0;
      st_valid_r  <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      quick_r     <= quick_nxt;
      st_valid_r  <= st_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r           <= op_nxt;
    val_r          <= val_nxt;
    pri_r          <= pri_nxt;
    quick_status_r <= quick_status_nxt;
    rd_idx_r       <= rd_idx_nxt;
    st_idx_r       <= st_idx_nxt;
    wr_idx_r       <= wr_idx_nxt;
    flag_r         <= flag_nxt;
    carry_value_r  <= carry_value_nxt;
    carry_pri_r    <= carry_pri_nxt;
    pend_valid_r   <= pend_valid_nxt;
    pend_value_r   <= pend_value_nxt;
    pend_pri_r     <= pend_pri_nxt;
    cnt_r          <= cnt_nxt;
    out_r          <= out_nxt;
  end

endmodule

/* design/sorted_priority_queue_unit.sv */
// The walk reads the sorted slots one at a time through the single read port of the slot
// memory, finishes the last slot, sees the walk end and then registers the closing result item.
// A new operation is accepted only once the previous one has closed; clear, unused codes,
// rejected operations and an insert into an empty queue walk no slots. A stalled result
// holds the walk. Reset (synchronous, rst_n low) empties the queue and drops any result.
module sorted_priority_queue_unit #(
  parameter int DEPTH          = spq_pkg::DEF_DEPTH,
  parameter int VALUE_WIDTH    = spq_pkg::DEF_VALUE_WIDTH,
  parameter int PRIORITY_WIDTH = spq_pkg::DEF_PRIORITY_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output spq_pkg::out_item_t out_data
);

  spq_pkg::spq_cmd_t cmd;
  spq_pkg::spq_sts_t sts;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  spq_datapath #(
    .DEPTH          (DEPTH),
    .VALUE_WIDTH    (VALUE_WIDTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
